FILE: rtl/core/pcbr_pkg.sv
// Package for the per-channel block reorder buffer.
// Holds default sizes, status codes and shared types. No dependencies.
package pcbr_pkg;
  localparam int CHANNELS_DEF = 256;
  localparam int WINDOW_DEF   = 16;
  localparam int TAG_BITS_DEF = 16;
  localparam int RUN_LIMIT    = 16;
  localparam int ID_BITS      = 32;
  localparam int CH_BITS      = 8;
  localparam int TAG_FIELD    = 16;

  localparam logic [1:0] ST_RELEASED = 2'd0;
  localparam logic [1:0] ST_STALE    = 2'd1;
  localparam logic [1:0] ST_BEYOND   = 2'd2;

  // one result as it leaves the block
  typedef struct packed {
    logic [CH_BITS-1:0]   channel;
    logic [ID_BITS-1:0]   block_num;
    logic [TAG_FIELD-1:0] tag;
    logic                 close;
    logic [1:0]           status;
    logic                 last;
  } result_t;
endpackage

FILE: rtl/core/pcbr_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
module pcbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/per_channel_block_reorder_top.sv
// Per-channel reorder buffer: releases numbered blocks in order per channel.
// Depends on pcbr_pkg and pcbr_ram.
//
// One item is handled at a time. Once accepted, an item passes through the
// channel-state read, the decide step (which parks the block or loads its own
// result), a parked-slot read and a release for each of the k parked blocks it
// drains, k = 0..16, and the state write-back; then the idle state accepts the
// next item. While the output register still holds an unaccepted transfer, the
// decide or release step stalls. Channel numbers fold onto CHANNELS entries by
// compare-and-subtract. After reset a clearing pass writes every channel-state
// entry before the first item is accepted.
module per_channel_block_reorder_top #(
  parameter int CHANNELS = pcbr_pkg::CHANNELS_DEF,
  parameter int WINDOW   = pcbr_pkg::WINDOW_DEF,
  parameter int TAG_BITS = pcbr_pkg::TAG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // channel[7:0], block_num[39:8], block_tag[55:40], close_flag[56], zeros
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_channel[7:0], out_block_num[39:8], out_tag[55:40], out_close[56], zeros
  output logic [63:0] m_tdata,
  // status[1:0]
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);
  localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WW  = $clog2(WINDOW);
  localparam int SW  = pcbr_pkg::ID_BITS + WINDOW + WW;  // expected, valid, head
  localparam int SD  = 1 << CW;
  localparam int PW  = TAG_BITS + 1;
  localparam int PAW = CW + WW;
  localparam int PD  = 1 << PAW;
  localparam int RCW = $clog2(pcbr_pkg::RUN_LIMIT + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_DEC   = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_DRN   = 3'd5;
  localparam logic [2:0] S_WB    = 3'd6;

  logic [2:0] state;
  logic [CW-1:0] clr_cnt;

  // captured input
  logic [7:0]          in_ch;
  logic [31:0]         in_id;
  logic [TAG_BITS-1:0] in_tag;
  logic                in_close;
  logic [CW-1:0]       cidx;

  // working copy of channel state
  logic [31:0]       nexp;
  logic [WINDOW-1:0] pvalid;
  logic [WW-1:0]     head;
  logic [RCW-1:0]    nres;

  // output register
  pcbr_pkg::result_t res;
  logic              res_valid;

  // RAM ports
  logic           st_we;
  logic [CW-1:0]  st_waddr, st_raddr;
  logic [SW-1:0]  st_wdata, st_rdata;
  logic           pk_we;
  logic [PAW-1:0] pk_waddr, pk_raddr;
  logic [PW-1:0]  pk_wdata, pk_rdata;

  pcbr_ram #(.WIDTH(SW), .DEPTH(SD)) u_state (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );
  pcbr_ram #(.WIDTH(PW), .DEPTH(PD)) u_park (
    .clk(clk), .we(pk_we), .waddr(pk_waddr), .wdata(pk_wdata),
    .raddr(pk_raddr), .rdata(pk_rdata)
  );

  // channel number modulo CHANNELS, restoring compare-and-subtract
  function automatic logic [CW-1:0] ch_index(input logic [7:0] ch);
    logic [19:0] r;
    r = {12'd0, ch};
    for (int k = 7; k >= 0; k--) begin
      if (r >= (20'(CHANNELS) << k)) r = r - (20'(CHANNELS) << k);
    end
    return CW'(r);
  endfunction

  // decision terms, from the working copy of the channel state
  logic [31:0]   delta;
  logic [WW:0]   slot_sum;
  logic [WW-1:0] slot;
  logic [WW-1:0] head_inc;
  logic          in_win;
  logic          is_park;
  logic          own_release;
  logic [1:0]    own_status;
  logic          drain_last;
  always_comb begin
    delta       = in_id - nexp;
    slot_sum    = {1'b0, head} + {1'b0, delta[WW-1:0]};
    slot        = (slot_sum >= (WW+1)'(WINDOW)) ? WW'(slot_sum - (WW+1)'(WINDOW))
                                                : WW'(slot_sum);
    head_inc    = (head == WW'(WINDOW - 1)) ? '0 : head + 1'b1;
    in_win      = (delta != '0) && (delta < 32'(WINDOW));
    is_park     = in_win && !pvalid[slot];
    own_release = (delta == '0) && !pvalid[head];
    priority if (own_release)  own_status = pcbr_pkg::ST_RELEASED;
    else if (delta == '0)      own_status = pcbr_pkg::ST_STALE;
    else if (in_win)           own_status = pcbr_pkg::ST_STALE;
    else if (delta[31])        own_status = pcbr_pkg::ST_STALE;
    else                       own_status = pcbr_pkg::ST_BEYOND;
    drain_last  = (nres == RCW'(pcbr_pkg::RUN_LIMIT - 1)) || !pvalid[head_inc];
  end

  logic out_free;
  logic res_load;
  assign out_free = !res_valid || m_tready;
  assign s_tready = (state == S_IDLE);
  assign res_load = out_free && ((state == S_DEC && !is_park) || state == S_DRN);

  // RAM addressing: clear pass, write-back, parking
  always_comb begin
    st_raddr = ch_index(s_tdata[7:0]);
    pk_raddr = {cidx, head};
    st_we    = (state == S_CLEAR) || (state == S_WB);
    st_waddr = (state == S_CLEAR) ? clr_cnt : cidx;
    st_wdata = (state == S_CLEAR) ? '0 : {nexp, pvalid, head};
    pk_we    = (state == S_DEC) && is_park;
    pk_waddr = {cidx, slot};
    pk_wdata = {in_close, in_tag};
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  // item sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CW'(CHANNELS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            in_ch    <= s_tdata[7:0];
            in_id    <= s_tdata[39:8];
            in_tag   <= TAG_BITS'(s_tdata[55:40]);
            in_close <= s_tdata[56];
            cidx     <= ch_index(s_tdata[7:0]);
            state    <= S_LOOK;
          end
        end
        S_LOOK: begin
          {nexp, pvalid, head} <= st_rdata;
          nres  <= '0;
          state <= S_DEC;
        end
        S_DEC: begin
          if (is_park) begin
            // parked: no result of its own, drain only a leftover run
            pvalid[slot] <= 1'b1;
            state        <= pvalid[head] ? S_RD : S_WB;
          end else if (out_free) begin
            res.channel   <= in_ch;
            res.block_num <= in_id;
            res.tag       <= pcbr_pkg::TAG_FIELD'(in_tag);
            res.close     <= in_close;
            res.status    <= own_status;
            nres          <= RCW'(1);
            if (own_release) begin
              nexp     <= nexp + 32'd1;
              head     <= head_inc;
              res.last <= !pvalid[head_inc];
              state    <= pvalid[head_inc] ? S_RD : S_WB;
            end else begin
              res.last <= !pvalid[head];
              state    <= pvalid[head] ? S_RD : S_WB;
            end
          end
        end
        S_RD: begin
          state <= S_DRN;   // parked slot at head is being read
        end
        S_DRN: begin
          if (out_free) begin
            res.channel   <= in_ch;
            res.block_num <= nexp;
            res.tag       <= pcbr_pkg::TAG_FIELD'(pk_rdata[TAG_BITS-1:0]);
            res.close     <= pk_rdata[TAG_BITS];
            res.status    <= pcbr_pkg::ST_RELEASED;
            res.last      <= drain_last;
            pvalid[head]  <= 1'b0;
            nexp          <= nexp + 32'd1;
            head          <= head_inc;
            nres          <= nres + 1'b1;
            state         <= drain_last ? S_WB : S_RD;
          end
        end
        S_WB: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {7'd0, res.close, res.tag, res.block_num, res.channel};
  assign m_tuser  = res.status;
  assign m_tlast  = res.last;

  // no result leaves while the clearing pass runs
  a_no_out_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !res_valid) else $error("result during clear");
  // input is only taken in idle
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state == S_LOOK) else $error("bad accept");
  // a pending output is held until it is taken
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !m_tready) |=> res_valid && $stable(m_tdata) &&
                                 $stable(m_tuser) && $stable(m_tlast))
    else $error("output overrun");
endmodule
